>>> src/cbtq_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbtq_pkg
// Shared types and constants for the button and trigger qualifier.
// ---------------------------------------------------------------------------
package cbtq_pkg;

  localparam int unsigned MASK_W = 64;
  localparam int unsigned TRIG_W = 8;
  localparam int unsigned IDX_W  = 6;

  // dead zone after reset (about 0.1 of full scale)
  localparam logic [TRIG_W-1:0] DEAD_ZONE_RST = 8'd26;
  // trigger scale end points: 0.0 and 1.0
  localparam logic [TRIG_W-1:0] TRIG_ZERO = 8'd0;
  localparam logic [TRIG_W-1:0] TRIG_FULL = 8'd255;

  // one poll word
  typedef struct packed {
    logic [MASK_W-1:0] pressed_mask;
    logic [MASK_W-1:0] touched_mask;
    logic [TRIG_W-1:0] trigger_value;
    logic              sensor_valid;
    logic [IDX_W-1:0]  button_index;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic pressed;
    logic press_down;
    logic press_up;
    logic touched;
    logic touch_down;
    logic touch_up;
    logic hair_active;
    logic hair_down;
    logic hair_up;
  } out_word_t;

endpackage
`default_nettype wire

>>> src/cbtq_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbtq_core
// Poll state (previous masks, hair-trigger latch, tracked limit, dead zone)
// and the single-pass logic that turns one poll word into one result word.
// ---------------------------------------------------------------------------
module cbtq_core (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       adv,
  input  wire cbtq_pkg::in_word_t         item,
  input  wire logic                       cfg_we,
  input  wire logic [cbtq_pkg::TRIG_W-1:0] cfg_wdata,
  output cbtq_pkg::out_word_t             result
);

  logic [cbtq_pkg::MASK_W-1:0] last_pressed_r, last_touched_r;
  logic                        latch_now_r, latch_before_r;
  logic [cbtq_pkg::TRIG_W-1:0] limit_r, dead_zone_r;

  logic                        mask_change;
  logic                        latch_nxt;
  logic [cbtq_pkg::TRIG_W-1:0] limit_nxt;
  logic [cbtq_pkg::TRIG_W:0]   v_plus_dz, lim_plus_dz;
  logic                        p_now, p_was, t_now, t_was;
  logic                        lat_new, lat_old, vld;

  // latch evaluation; compares kept 9 bits wide so limit +/- dead zone never wraps
  always_comb begin
    mask_change = (item.pressed_mask != last_pressed_r);
    v_plus_dz   = {1'b0, item.trigger_value} + {1'b0, dead_zone_r};
    lim_plus_dz = {1'b0, limit_r} + {1'b0, dead_zone_r};
    if (latch_now_r) begin
      latch_nxt = !((v_plus_dz < {1'b0, limit_r}) ||
                    (item.trigger_value == cbtq_pkg::TRIG_ZERO));
    end else begin
      latch_nxt = ({1'b0, item.trigger_value} > lim_plus_dz) ||
                  (item.trigger_value == cbtq_pkg::TRIG_FULL);
    end
    if (latch_nxt) begin
      limit_nxt = (item.trigger_value > limit_r) ? item.trigger_value : limit_r;
    end else begin
      limit_nxt = (item.trigger_value < limit_r) ? item.trigger_value : limit_r;
    end
  end

  // level and edge results for the queried button
  always_comb begin
    p_now   = item.pressed_mask[item.button_index];
    p_was   = last_pressed_r[item.button_index];
    t_now   = item.touched_mask[item.button_index];
    t_was   = last_touched_r[item.button_index];
    lat_new = mask_change ? latch_nxt : latch_now_r;
    lat_old = mask_change ? latch_now_r : latch_before_r;
    vld     = item.sensor_valid;

    result.pressed     = vld & p_now;
    result.press_down  = vld & p_now & ~p_was;
    result.press_up    = vld & ~p_now & p_was;
    result.touched     = vld & t_now;
    result.touch_down  = vld & t_now & ~t_was;
    result.touch_up    = vld & ~t_now & t_was;
    result.hair_active = vld & lat_new;
    result.hair_down   = vld & lat_new & ~lat_old;
    result.hair_up     = vld & ~lat_new & lat_old;
  end

  // state update, once per word that moves to the result register; dead zone written on cfg_we
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pressed_r <= '0;
      last_touched_r <= '0;
      latch_now_r    <= 1'b0;
      latch_before_r <= 1'b0;
      limit_r        <= '0;
      dead_zone_r    <= cbtq_pkg::DEAD_ZONE_RST;
    end else begin
      if (cfg_we) begin
        dead_zone_r <= cfg_wdata;
      end
      if (adv) begin
        last_pressed_r <= item.pressed_mask;
        last_touched_r <= item.touched_mask;
        if (mask_change) begin
          latch_before_r <= latch_now_r;
          latch_now_r    <= latch_nxt;
          limit_r        <= limit_nxt;
        end
      end
    end
  end

`ifndef SYNTH
  // latch state moves only on a pressed-mask change
  a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(adv && mask_change) |=> $stable({latch_now_r, latch_before_r, limit_r}))
    else $error("latch state changed without a pressed-mask change");

  // an evaluation shifts the old level into latch_before
  a_latch_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mask_change) |=> (latch_before_r == $past(latch_now_r)))
    else $error("latch_before did not take the prior level");

  // while latched the limit tracks at least the trigger value of that poll
  a_limit_track: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mask_change && latch_nxt) |=> (limit_r >= $past(item.trigger_value)))
    else $error("tracked limit below trigger value while latched");
`endif

endmodule
`default_nettype wire

>>> src/controller_button_and_trigger_qualifier.sv
// Path: a word accepted into the input register moves through the core logic into the result
//   register, which drives out_valid; a stall on out_ready holds it in the input register.
// Throughput: one word per cycle when not stalled; the input register and result register form a
//   two-stage pipe that advances whenever the result register is empty or taken.
// Reset (rst_n low, synchronous): both stages empty, previous masks, latch and
//   tracked limit cleared, dead zone set to 26.
`default_nettype none
// ---------------------------------------------------------------------------
// controller_button_and_trigger_qualifier
// Button level/edge detect and hair-trigger latch, one poll word per cycle unless stalled.
// ---------------------------------------------------------------------------
module controller_button_and_trigger_qualifier (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire cbtq_pkg::in_word_t          in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output cbtq_pkg::out_word_t              out_data,
  input  wire logic                        cfg_we,
  input  wire logic [cbtq_pkg::TRIG_W-1:0] cfg_wdata
);

  logic                stg_valid_r;
  cbtq_pkg::in_word_t  stg_data_r;
  logic                out_valid_r;
  cbtq_pkg::out_word_t out_data_r;
  cbtq_pkg::out_word_t core_result;
  logic                adv;

  // stage handshake: a word moves on when the result register is free or drained
  assign adv      = stg_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !stg_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stg_data_r <= in_data;
    end
  end

  cbtq_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .item      (stg_data_r),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (core_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> tb/sv/cbtq_poll_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbtq_poll_checker
// Watches the poll and result channels of the button and trigger qualifier,
// predicts each result word from its own copy of the edge and latch state,
// and compares the words field by field in order.
// ---------------------------------------------------------------------------
module cbtq_poll_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  cbtq_pkg::in_word_t          in_data,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  cbtq_pkg::out_word_t         out_data,
  input  logic                        cfg_we,
  input  logic [cbtq_pkg::TRIG_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending
);

  // predicted copy of the block state
  logic [cbtq_pkg::MASK_W-1:0] prev_pressed;
  logic [cbtq_pkg::MASK_W-1:0] prev_touched;
  logic                        latch_level;
  logic                        latch_prior;
  logic [cbtq_pkg::TRIG_W-1:0] limit_track;
  logic [cbtq_pkg::TRIG_W-1:0] dz_setting;

  cbtq_pkg::out_word_t expected_words[$];
  int                  errors;

  assign fail_count = errors;

  // one poll through the edge detector and the hair-trigger latch
  function automatic cbtq_pkg::out_word_t qualify_poll(input cbtq_pkg::in_word_t w);
    cbtq_pkg::out_word_t r;
    logic                p_now, p_was, t_now, t_was;
    int                  lim, dz, v;
    p_now = w.pressed_mask[w.button_index];
    p_was = prev_pressed[w.button_index];
    t_now = w.touched_mask[w.button_index];
    t_was = prev_touched[w.button_index];
    // latch only moves when the pressed mask changes
    if (w.pressed_mask != prev_pressed) begin
      lim = int'(limit_track);
      dz  = int'(dz_setting);
      v   = int'(w.trigger_value);
      latch_prior = latch_level;
      if (latch_level) begin
        if (v < lim - dz || w.trigger_value == cbtq_pkg::TRIG_ZERO) latch_level = 1'b0;
      end else if (v > lim + dz || w.trigger_value == cbtq_pkg::TRIG_FULL) begin
        latch_level = 1'b1;
      end
      // limit follows the trigger up while latched, down while not
      if (latch_level) begin
        if (w.trigger_value > limit_track) limit_track = w.trigger_value;
      end else if (w.trigger_value < limit_track) begin
        limit_track = w.trigger_value;
      end
    end
    prev_pressed  = w.pressed_mask;
    prev_touched  = w.touched_mask;
    r.pressed     = w.sensor_valid & p_now;
    r.press_down  = w.sensor_valid & p_now & ~p_was;
    r.press_up    = w.sensor_valid & ~p_now & p_was;
    r.touched     = w.sensor_valid & t_now;
    r.touch_down  = w.sensor_valid & t_now & ~t_was;
    r.touch_up    = w.sensor_valid & ~t_now & t_was;
    r.hair_active = w.sensor_valid & latch_level;
    r.hair_down   = w.sensor_valid & latch_level & ~latch_prior;
    r.hair_up     = w.sensor_valid & ~latch_level & latch_prior;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic exp_b,
                                      input logic act_b);
    if (exp_b !== act_b) begin
      $error("%s: expected %0b, got %0b", name, exp_b, act_b);
      errors++;
    end
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  // sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    cbtq_pkg::out_word_t exp_w;
    if (!rst_n) begin
      prev_pressed = '0;
      prev_touched = '0;
      latch_level  = 1'b0;
      latch_prior  = 1'b0;
      limit_track  = '0;
      dz_setting   = cbtq_pkg::DEAD_ZONE_RST;
      expected_words.delete();
    end else begin
      if (in_valid && in_ready) expected_words.push_back(qualify_poll(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("result word with no poll waiting");
          errors++;
        end else begin
          exp_w = expected_words.pop_front();
          check_field("pressed",     exp_w.pressed,     out_data.pressed);
          check_field("press_down",  exp_w.press_down,  out_data.press_down);
          check_field("press_up",    exp_w.press_up,    out_data.press_up);
          check_field("touched",     exp_w.touched,     out_data.touched);
          check_field("touch_down",  exp_w.touch_down,  out_data.touch_down);
          check_field("touch_up",    exp_w.touch_up,    out_data.touch_up);
          check_field("hair_active", exp_w.hair_active, out_data.hair_active);
          check_field("hair_down",   exp_w.hair_down,   out_data.hair_down);
          check_field("hair_up",     exp_w.hair_up,     out_data.hair_up);
        end
      end
      if (cfg_we) dz_setting = cfg_wdata;
    end
    pending = expected_words.size();
  end

endmodule

>>> tb/sv/tb_controller_button_and_trigger_qualifier.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_controller_button_and_trigger_qualifier
// Drives directed and random controller polls through several dead zone
// settings with random stalls on both sides; the poll checker predicts and
// compares every result word, and this module reports the verdict.
// ---------------------------------------------------------------------------
module tb_controller_button_and_trigger_qualifier;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int NUM_PHASES      = 6;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  cbtq_pkg::in_word_t          in_data;
  logic                        out_valid;
  logic                        out_ready;
  cbtq_pkg::out_word_t         out_data;
  logic                        cfg_we;
  logic [cbtq_pkg::TRIG_W-1:0] cfg_wdata;

  int fail_count;
  int pending;
  int cycles;
  bit quiet;       // no idling on either side
  bit hold_req;    // ask the receiver for one long stall

  logic [cbtq_pkg::MASK_W-1:0] pm_cur;
  logic [cbtq_pkg::MASK_W-1:0] tm_cur;

  controller_button_and_trigger_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  cbtq_poll_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // offer one poll word; returns at the falling edge after it was taken
  task automatic send_poll(input logic [cbtq_pkg::MASK_W-1:0] pm,
                           input logic [cbtq_pkg::MASK_W-1:0] tm,
                           input logic [cbtq_pkg::TRIG_W-1:0] trig, input logic vld,
                           input logic [cbtq_pkg::IDX_W-1:0] idx);
    cbtq_pkg::in_word_t w;
    w.pressed_mask  = pm;
    w.touched_mask  = tm;
    w.trigger_value = trig;
    w.sensor_valid  = vld;
    w.button_index  = idx;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // random gap on the sender side
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  function automatic logic [cbtq_pkg::TRIG_W-1:0] pick_trigger();
    case ($urandom_range(0, 5))
      0:       return cbtq_pkg::TRIG_ZERO;
      1:       return cbtq_pkg::TRIG_FULL;
      2:       return cbtq_pkg::TRIG_W'($urandom_range(0, 40));
      3:       return cbtq_pkg::TRIG_W'($urandom_range(215, 255));
      default: return cbtq_pkg::TRIG_W'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly small changes to the masks so that queried bits see real edges
  task automatic random_poll();
    int flip;
    logic [cbtq_pkg::IDX_W-1:0] idx;
    flip = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       pm_cur = {$urandom, $urandom};
      1, 2:    ;
      default: begin
        pm_cur[flip] = ~pm_cur[flip];
        if ($urandom_range(0, 2) == 0) pm_cur[$urandom_range(0, 63)] ^= 1'b1;
      end
    endcase
    case ($urandom_range(0, 7))
      0:       tm_cur = {$urandom, $urandom};
      1, 2:    ;
      default: tm_cur[flip] = ~tm_cur[flip];
    endcase
    idx = ($urandom_range(0, 1) == 0) ? cbtq_pkg::IDX_W'(flip) :
                                        cbtq_pkg::IDX_W'($urandom_range(0, 63));
    send_poll(pm_cur, tm_cur, pick_trigger(), ($urandom_range(0, 9) != 0), idx);
  endtask

  // drain, then write the dead zone while the block is idle
  task automatic set_dead_zone(input logic [cbtq_pkg::TRIG_W-1:0] dz);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= dz;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // receiver: random stalls, one long hold on request
  initial begin
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (80) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
  end

  // stimulus
  initial begin
    logic [cbtq_pkg::TRIG_W-1:0] dz;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    pm_cur    = '0;
    tm_cur    = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: edges at both ends of the index, latch set and clear paths
    send_poll('0, '0, cbtq_pkg::TRIG_ZERO, 1'b1, 6'd0);    // no change, no latch update
    send_poll('1, '1, cbtq_pkg::TRIG_FULL, 1'b1, 6'd63);   // full pull sets latch
    send_poll('0, '0, 8'd200, 1'b1, 6'd63);               // below limit minus dead zone
    send_poll(64'd1, '0, 8'd240, 1'b1, 6'd0);             // above limit plus dead zone
    send_poll(64'd1, '0, cbtq_pkg::TRIG_ZERO, 1'b1, 6'd0); // same mask: latch holds
    send_poll(64'd3, 64'd1, cbtq_pkg::TRIG_ZERO, 1'b0, 6'd1); // invalid poll, state moves
    send_poll(64'd2, 64'd1, 8'd20, 1'b1, 6'd1);           // inside dead zone
    send_poll(64'd4, '0, 8'd27, 1'b1, 6'd0);              // just over the dead zone
    send_poll(64'd5, '0, 8'd1, 1'b1, 6'd2);               // exactly limit minus dead zone
    send_poll(64'd6, '0, cbtq_pkg::TRIG_ZERO, 1'b1, 6'd0); // zero clears latch
    send_poll(64'h8000_0000_0000_0000, '1, cbtq_pkg::TRIG_FULL, 1'b1, 6'd63);
    send_poll(64'h8000_0000_0000_0000, '0, cbtq_pkg::TRIG_FULL, 1'b0, 6'd63);
    send_poll(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'd128, 1'b1, 6'd62);
    send_poll(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'd127, 1'b1, 6'd62);
    send_poll('1, '1, cbtq_pkg::TRIG_ZERO, 1'b1, 6'd31);
    send_poll('0, '0, cbtq_pkg::TRIG_FULL, 1'b1, 6'd32);
    pm_cur = '0;
    tm_cur = '0;

    // random phases over several dead zone settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       dz = 8'd0;
        1:       dz = 8'd255;
        2:       dz = 8'd1;
        3:       dz = 8'd254;
        4:       dz = cbtq_pkg::TRIG_W'($urandom_range(2, 253));
        default: dz = cbtq_pkg::DEAD_ZONE_RST;
      endcase
      set_dead_zone(dz);
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (ph == 2 && i == 50) hold_req = 1'b1;   // back-pressure fills the pipe
        random_poll();
        sender_gap();
      end
    end
    in_valid <= 1'b0;

    // drain and settle
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
